// ===== rtl/core/http_byte_range_parser_defines.svh =====
// Assertion helpers shared by the byte range parser modules.
`ifndef HTTP_BYTE_RANGE_PARSER_DEFINES_SVH
`define HTTP_BYTE_RANGE_PARSER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HBR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hbr assertion failed");

// Next-cycle implication, checked out of reset.
`define HBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hbr assertion failed");

`endif

// ===== rtl/core/hbr_pkg.sv =====
package hbr_pkg;

    localparam int MAX_BODY_CHARS_DEF = 127;

    localparam logic [2:0] PREFIX_LEN = 3'd6;
    localparam logic [7:0] PREFIX_TEXT [0:5] = '{8'h62, 8'h79, 8'h74, 8'h65, 8'h73, 8'h3D};

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [63:0] MAG_CAP   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        SCAN_WS     = 2'd0,
        SCAN_SIGN   = 2'd1,
        SCAN_DIGITS = 2'd2,
        SCAN_STOP   = 2'd3
    } scan_phase_t;

    // One strtoll-style number scan: magnitude saturates at 2^63.
    typedef struct packed {
        scan_phase_t phase;
        logic        neg;
        logic [63:0] mag;
    } scan_t;

    typedef struct packed {
        logic [2:0]         prefix_cnt;
        logic               prefix_failed;
        logic               string_ended;
        scan_t              lead;
        logic               lead_nonempty;
        logic               dash_seen;
        logic signed [63:0] split_value;
        logic               split_nonempty;
        scan_t              tail;
        logic               tail_nonempty;
    } parse_state_t;

    // Parse outcome at the last byte of a header.
    typedef struct packed {
        logic               ok;
        logic               split_nonempty;
        logic signed [63:0] split_value;
        logic               tail_nonempty;
        scan_t              tail;
        logic [62:0]        size;
    } snap_t;

    typedef struct packed {
        logic               ok;
        logic               split_nonempty;
        logic signed [63:0] start_clamp;
        logic               tail_nonempty;
        logic signed [63:0] tail_value;
        logic [62:0]        size;
    } mid_t;

    function automatic logic is_space(logic [7:0] c);
        return c inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
    endfunction

    function automatic scan_t scan_step(scan_t s, logic [7:0] c);
        logic        digit;
        logic [3:0]  d;
        logic [67:0] prod;
        scan_t       r;
        digit = c inside {[CHAR_ZERO:CHAR_NINE]};
        d     = digit ? 4'(c - CHAR_ZERO) : 4'd0;
        prod  = ({4'b0, s.mag} << 3) + ({4'b0, s.mag} << 1) + 68'(d);
        r     = s;
        case (s.phase)
            SCAN_WS: begin
                if (is_space(c)) begin
                    r = s;
                end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
                    r.neg   = (c == CHAR_DASH);
                    r.phase = SCAN_SIGN;
                end else if (digit) begin
                    r.mag   = 64'(d);
                    r.phase = SCAN_DIGITS;
                end else begin
                    r.phase = SCAN_STOP;
                end
            end
            SCAN_SIGN: begin
                if (digit) begin
                    r.mag   = 64'(d);
                    r.phase = SCAN_DIGITS;
                end else begin
                    r.phase = SCAN_STOP;
                end
            end
            SCAN_DIGITS: begin
                if (digit) begin
                    r.mag = (prod > {4'b0, MAG_CAP}) ? MAG_CAP : prod[63:0];
                end else begin
                    r.phase = SCAN_STOP;
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] scan_result(logic neg, logic [63:0] mag);
        logic signed [63:0] v;
        if (neg) begin
            v = (mag >= MAG_CAP) ? $signed(MAG_CAP) : -$signed(mag);
        end else begin
            v = (mag > INT64_MAX) ? $signed(INT64_MAX) : $signed(mag);
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/hbr_parse.sv =====
`include "http_byte_range_parser_defines.svh"

module hbr_parse #(
    parameter int MAX_BODY_CHARS = hbr_pkg::MAX_BODY_CHARS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_last,
    input  logic [62:0]   in_size,
    output logic          snap_valid,
    input  logic          snap_ready,
    output hbr_pkg::snap_t snap
);

    localparam int BW = $clog2(MAX_BODY_CHARS + 1);

    logic                  in_vld_reg;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    logic [62:0]           in_size_reg;
    logic                  consume;

    hbr_pkg::parse_state_t st_reg, st_next, st_upd;
    logic [BW-1:0]         body_cnt_reg, body_cnt_next, body_cnt_upd;
    logic                  snap_vld_reg, snap_vld_next;
    hbr_pkg::snap_t        snap_reg, snap_next;

    // A plain byte always drains; a last byte waits for the snapshot slot.
    assign consume  = in_vld_reg && (!in_last_reg || !snap_vld_reg || snap_ready);
    assign in_ready = !in_vld_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
        if (in_ready) begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
            in_size_reg <= in_size;
        end
    end

    always_comb begin
        st_upd       = st_reg;
        body_cnt_upd = body_cnt_reg;
        if (!st_reg.string_ended && !st_reg.prefix_failed) begin
            if (in_byte_reg == hbr_pkg::CHAR_NUL) begin
                st_upd.string_ended = 1'b1;
                if (st_reg.prefix_cnt < hbr_pkg::PREFIX_LEN) begin
                    st_upd.prefix_failed = 1'b1;
                end
            end else if (st_reg.prefix_cnt < hbr_pkg::PREFIX_LEN) begin
                if (in_byte_reg == hbr_pkg::PREFIX_TEXT[st_reg.prefix_cnt]) begin
                    st_upd.prefix_cnt = st_reg.prefix_cnt + 3'd1;
                end else begin
                    st_upd.prefix_failed = 1'b1;
                end
            end else if (body_cnt_reg < BW'(MAX_BODY_CHARS)) begin
                body_cnt_upd = body_cnt_reg + BW'(1);
                if (in_byte_reg == hbr_pkg::CHAR_DASH) begin
                    // Freeze the start part and restart the end-part scan.
                    st_upd.split_value    = hbr_pkg::scan_result(st_reg.lead.neg,
                                                                 st_reg.lead.mag);
                    st_upd.split_nonempty = st_reg.lead_nonempty;
                    st_upd.dash_seen      = 1'b1;
                    st_upd.tail           = '0;
                    st_upd.tail_nonempty  = 1'b0;
                end else begin
                    st_upd.tail          = hbr_pkg::scan_step(st_reg.tail, in_byte_reg);
                    st_upd.tail_nonempty = 1'b1;
                end
                st_upd.lead          = hbr_pkg::scan_step(st_reg.lead, in_byte_reg);
                st_upd.lead_nonempty = 1'b1;
            end
        end
    end

    always_comb begin
        st_next       = st_reg;
        body_cnt_next = body_cnt_reg;
        snap_vld_next = snap_vld_reg && !snap_ready;
        snap_next     = snap_reg;
        if (consume) begin
            st_next       = st_upd;
            body_cnt_next = body_cnt_upd;
            if (in_last_reg) begin
                snap_vld_next            = 1'b1;
                snap_next.ok             = !st_upd.prefix_failed && st_upd.dash_seen &&
                                           (st_upd.prefix_cnt == hbr_pkg::PREFIX_LEN);
                snap_next.split_nonempty = st_upd.split_nonempty;
                snap_next.split_value    = st_upd.split_value;
                snap_next.tail_nonempty  = st_upd.tail_nonempty;
                snap_next.tail           = st_upd.tail;
                snap_next.size           = in_size_reg;
                // Start the next header from scratch.
                st_next       = '0;
                body_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= '0;
            body_cnt_reg <= '0;
            snap_vld_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            body_cnt_reg <= body_cnt_next;
            snap_vld_reg <= snap_vld_next;
        end
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_vld_reg;
    assign snap       = snap_reg;

    `HBR_ASSERT_NEXT(a_clear_after_last, aclk, aresetn, consume && in_last_reg, st_reg.prefix_cnt == 3'd0 && body_cnt_reg == '0 && !st_reg.dash_seen)
    `HBR_ASSERT_IMP(a_dash_needs_prefix, aclk, aresetn, st_reg.dash_seen, st_reg.prefix_cnt == hbr_pkg::PREFIX_LEN && body_cnt_reg != '0)
    `HBR_ASSERT_NEXT(a_snap_held, aclk, aresetn, snap_vld_reg && !snap_ready, snap_vld_reg && $stable(snap_reg))

endmodule

// ===== rtl/core/hbr_resolve.sv =====
module hbr_resolve (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           snap_valid,
    output logic           snap_ready,
    input  hbr_pkg::snap_t snap,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           range_valid,
    output logic [62:0]    range_start,
    output logic [63:0]    range_end
);

    logic                mid_vld_reg;
    hbr_pkg::mid_t       mid_reg, mid_next;
    logic                mid_ready;

    logic                out_vld_reg;
    logic                valid_reg, valid_next;
    logic [62:0]         start_reg, start_next;
    logic signed [63:0]  end_reg, end_next;
    logic                out_en;

    logic signed [63:0]  sz, szm1, tail_v, s_v, e_v, suf_start;

    assign out_en     = !out_vld_reg || out_ready;
    assign mid_ready  = !mid_vld_reg || out_en;
    assign snap_ready = mid_ready;

    // Stage A: signed end value and clamped start.
    always_comb begin
        mid_next.ok             = snap.ok;
        mid_next.split_nonempty = snap.split_nonempty;
        mid_next.start_clamp    = snap.split_value[63] ? 64'sd0 : snap.split_value;
        mid_next.tail_nonempty  = snap.tail_nonempty;
        mid_next.tail_value     = hbr_pkg::scan_result(snap.tail.neg, snap.tail.mag);
        mid_next.size           = snap.size;
    end

    // Stage B: suffix or explicit range, then the fallback.
    always_comb begin
        sz        = $signed({1'b0, mid_reg.size});
        szm1      = sz - 64'sd1;
        tail_v    = mid_reg.tail_value;
        s_v       = mid_reg.start_clamp;
        e_v       = mid_reg.tail_nonempty ? tail_v : szm1;
        suf_start = sz - tail_v;
        valid_next = 1'b0;
        start_next = '0;
        end_next   = szm1;
        if (mid_reg.ok) begin
            if (!mid_reg.split_nonempty) begin
                if (mid_reg.tail_nonempty && tail_v > 64'sd0) begin
                    valid_next = 1'b1;
                    start_next = suf_start[63] ? 63'd0 : suf_start[62:0];
                end
            end else if (s_v <= e_v && s_v <= szm1) begin
                valid_next = 1'b1;
                start_next = s_v[62:0];
                end_next   = (e_v > szm1) ? szm1 : e_v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (mid_ready) begin
                mid_vld_reg <= snap_valid;
            end
            if (out_en) begin
                out_vld_reg <= mid_vld_reg;
            end
        end
        if (mid_ready) begin
            mid_reg <= mid_next;
        end
        if (out_en) begin
            valid_reg <= valid_next;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign range_valid = valid_reg;
    assign range_start = start_reg;
    assign range_end   = end_reg;

endmodule

// ===== rtl/core/http_byte_range_parser.sv =====
// Range header parser.
// Input stream: one header character per word on s_axis, with the resource size
// alongside; s_axis_tlast marks the final character of a header. Text must open
// with "bytes=", parsing stops at a zero character, and body characters past
// MAX_BODY_CHARS are dropped.
// Output stream: one word per header, produced only for the tlast input word,
// carrying the validity flag, the first offset and the inclusive last offset.
// An invalid range reports start 0 and end size-1.
// Throughput: one input word per cycle while results are not backing up. Every
// character only updates a small scan state (one multiply-by-ten and compare per number scan).
// Result path: after the tlast word is accepted, the result passes the input register,
// the parse snapshot, the end-value stage and the output register.
// Stall: a stalled result holds in the output register; non-final characters
// keep flowing in until results back up through all three stages.
// Reset: aresetn low clears the parse state and empties the pipeline; the
// first word after reset starts a new header.
module http_byte_range_parser #(
    parameter int MAX_BODY_CHARS = hbr_pkg::MAX_BODY_CHARS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // [7:0] header_byte, [70:8] resource_size
    input  logic          s_axis_tlast,   // last_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // [62:0] range_start, [126:63] range_end
    output logic [0:0]    m_axis_tuser    // [0] range_valid
);

    logic           snap_valid;
    logic           snap_ready;
    hbr_pkg::snap_t snap;
    logic           range_valid;
    logic [62:0]    range_start;
    logic [63:0]    range_end;

    hbr_parse #(
        .MAX_BODY_CHARS(MAX_BODY_CHARS)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata[7:0]),
        .in_last    (s_axis_tlast),
        .in_size    (s_axis_tdata[70:8]),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    hbr_resolve u_resolve (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .snap        (snap),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .range_valid (range_valid),
        .range_start (range_start),
        .range_end   (range_end)
    );

    assign m_axis_tdata = {1'b0, range_end, range_start};
    assign m_axis_tuser = range_valid;

endmodule

// ===== tb/sv/http_byte_range_parser_checker.sv =====
`timescale 1ns / 1ps

module http_byte_range_parser_checker #(
    parameter int BODY_LIMIT = hbr_pkg::MAX_BODY_CHARS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // [7:0] header_byte, [70:8] resource_size
    input  logic          s_axis_tlast,   // last_byte
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [127:0]  m_axis_tdata,   // [62:0] range_start, [126:63] range_end
    input  logic [0:0]    m_axis_tuser,   // [0] range_valid
    output int            mismatch_count,
    output int            ranges_outstanding
);
    import hbr_pkg::*;

    typedef struct packed {
        scan_phase_t phase;
        logic        neg;
        logic [63:0] mag;
    } number_scan_t;

    typedef struct packed {
        logic               ok;
        logic [62:0]        from_off;
        logic signed [63:0] to_off;
    } byte_range_t;

    localparam number_scan_t SCAN_IDLE = '{SCAN_WS, 1'b0, 64'd0};

    byte_range_t        pending_ranges[$];
    int                 bad_seen = 0;
    logic [2:0]         prefix_pos;
    logic               prefix_bad;
    int                 body_len;
    logic               text_done;
    number_scan_t       whole_scan;
    number_scan_t       after_scan;
    logic               body_any;
    logic               dash_any;
    logic               before_any;
    logic               after_any;
    logic signed [63:0] before_val;

    function automatic void clear_parse();
        prefix_pos = '0;
        prefix_bad = 1'b0;
        body_len   = 0;
        text_done  = 1'b0;
        whole_scan = SCAN_IDLE;
        after_scan = SCAN_IDLE;
        body_any   = 1'b0;
        dash_any   = 1'b0;
        before_any = 1'b0;
        after_any  = 1'b0;
        before_val = '0;
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // base-10 scan: blanks, optional sign, digits; magnitude pinned at 2^63
    function automatic number_scan_t scan_advance(number_scan_t s, logic [7:0] c);
        logic        is_digit;
        logic [63:0] d;
        number_scan_t r;
        is_digit = c >= CHAR_ZERO && c <= CHAR_NINE;
        d        = is_digit ? 64'(c - CHAR_ZERO) : 64'd0;
        r        = s;
        case (s.phase)
            SCAN_WS: begin
                if (is_blank(c)) begin
                    r = s;
                end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
                    r.neg   = (c == CHAR_DASH);
                    r.phase = SCAN_SIGN;
                end else if (is_digit) begin
                    r.mag   = d;
                    r.phase = SCAN_DIGITS;
                end else begin
                    r.phase = SCAN_STOP;
                end
            end
            SCAN_SIGN: begin
                if (is_digit) begin
                    r.mag   = d;
                    r.phase = SCAN_DIGITS;
                end else begin
                    r.phase = SCAN_STOP;
                end
            end
            SCAN_DIGITS: begin
                if (!is_digit) begin
                    r.phase = SCAN_STOP;
                end else if (s.mag > (MAG_CAP - d) / 64'd10) begin
                    r.mag = MAG_CAP;
                end else begin
                    r.mag = s.mag * 64'd10 + d;
                end
            end
            default: r = s;
        endcase
        return r;
    endfunction

    function automatic logic signed [63:0] scan_value(number_scan_t s);
        if (s.mag == MAG_CAP)
            return s.neg ? $signed(MAG_CAP) : $signed(INT64_MAX);
        return s.neg ? -$signed(s.mag) : $signed(s.mag);
    endfunction

    function automatic void take_header_byte(logic [7:0] c);
        if (text_done || prefix_bad)
            return;
        if (c == CHAR_NUL) begin
            text_done = 1'b1;
            if (prefix_pos < PREFIX_LEN)
                prefix_bad = 1'b1;
        end else if (prefix_pos < PREFIX_LEN) begin
            if (c == PREFIX_TEXT[prefix_pos])
                prefix_pos++;
            else
                prefix_bad = 1'b1;
        end else if (body_len < BODY_LIMIT) begin
            body_len++;
            // each dash restarts the end part and freezes the start part
            if (c == CHAR_DASH) begin
                before_val = scan_value(whole_scan);
                before_any = body_any;
                dash_any   = 1'b1;
                after_scan = SCAN_IDLE;
                after_any  = 1'b0;
            end else begin
                after_scan = scan_advance(after_scan, c);
                after_any  = 1'b1;
            end
            whole_scan = scan_advance(whole_scan, c);
            body_any   = 1'b1;
        end
    endfunction

    function automatic byte_range_t resolve_range(logic [62:0] res_size);
        logic signed [63:0] total;
        logic signed [63:0] tail_num;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        byte_range_t        r;
        total = $signed({1'b0, res_size});
        r.ok  = 1'b0;
        lo    = '0;
        hi    = total - 1;
        if (!prefix_bad && prefix_pos == PREFIX_LEN && dash_any) begin
            tail_num = scan_value(after_scan);
            if (!before_any) begin
                // suffix form: last N bytes
                if (after_any && tail_num > 0) begin
                    lo = total - tail_num;
                    if (lo < 0)
                        lo = '0;
                    r.ok = 1'b1;
                end
            end else begin
                lo = before_val;
                hi = after_any ? tail_num : total - 1;
                if (lo < 0)
                    lo = '0;
                if (hi >= total)
                    hi = total - 1;
                r.ok = (lo <= hi);
            end
        end
        if (!r.ok) begin
            lo = '0;
            hi = total - 1;
        end
        r.from_off = lo[62:0];
        r.to_off   = hi;
        return r;
    endfunction

    always @(posedge aclk) begin
        byte_range_t        want;
        logic signed [63:0] got_end;
        if (!aresetn) begin
            clear_parse();
            pending_ranges.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_end = $signed(m_axis_tdata[126:63]);
                if (pending_ranges.size() == 0) begin
                    $error("result word with no range pending");
                    bad_seen++;
                end else begin
                    want = pending_ranges.pop_front();
                    if (m_axis_tuser[0] !== want.ok) begin
                        $error("range_valid: expected %0d, got %0d", want.ok, m_axis_tuser[0]);
                        bad_seen++;
                    end
                    if (m_axis_tdata[62:0] !== want.from_off) begin
                        $error("range_start: expected %0d, got %0d",
                               want.from_off, m_axis_tdata[62:0]);
                        bad_seen++;
                    end
                    if (got_end !== want.to_off) begin
                        $error("range_end: expected %0d, got %0d", want.to_off, got_end);
                        bad_seen++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_header_byte(s_axis_tdata[7:0]);
                if (s_axis_tlast) begin
                    pending_ranges.push_back(resolve_range(s_axis_tdata[70:8]));
                    clear_parse();
                end
            end
        end
        mismatch_count     <= bad_seen;
        ranges_outstanding <= pending_ranges.size();
    end

endmodule

// ===== tb/sv/tb_http_byte_range_parser.sv =====
`timescale 1ns / 1ps

module tb_http_byte_range_parser;
    import hbr_pkg::*;

    localparam logic [62:0] SIZE_MAX     = '1;
    localparam int          RANDOM_BYTES = 1500;

    logic         aclk          = 1'b0;
    logic         aresetn       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata  = '0;   // [7:0] header_byte, [70:8] resource_size
    logic         s_axis_tlast  = 1'b0; // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;         // [62:0] range_start, [126:63] range_end
    logic [0:0]   m_axis_tuser;         // [0] range_valid

    int           mismatch_count;
    int           ranges_outstanding;
    bit           idle_on    = 1'b1;
    int           bytes_sent = 0;
    logic [7:0]   hdr[$];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    http_byte_range_parser u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    http_byte_range_parser_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_axis_tvalid      (s_axis_tvalid),
        .s_axis_tready      (s_axis_tready),
        .s_axis_tdata       (s_axis_tdata),
        .s_axis_tlast       (s_axis_tlast),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tuser       (m_axis_tuser),
        .mismatch_count     (mismatch_count),
        .ranges_outstanding (ranges_outstanding)
    );

    task automatic send_word(logic [7:0] c, logic fin, logic [62:0] res_size);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, res_size, c};
        s_axis_tlast  <= fin;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // size only matters on the final word; the rest carry noise
    task automatic send_header(logic [62:0] res_size);
        for (int i = 0; i < hdr.size(); i++) begin
            if (i == hdr.size() - 1)
                send_word(hdr[i], 1'b1, res_size);
            else
                send_word(hdr[i], 1'b0, 63'({$urandom, $urandom}));
        end
        hdr.delete();
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            hdr.push_back(s[i]);
    endtask

    task automatic run_case(string s, logic [62:0] res_size);
        add_text(s);
        send_header(res_size);
    endtask

    // hold off until every expected range has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (ranges_outstanding != 0)
            @(negedge aclk);
    endtask

    function automatic logic [62:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 63'({$urandom, $urandom});
            2:       return SIZE_MAX;
            default: return 63'($urandom_range(0, 5000));
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            default: return 8'($urandom_range(CHAR_TAB, CHAR_CR));
        endcase
    endfunction

    task automatic add_number();
        int digits;
        if ($urandom_range(0, 3) == 0)
            return;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) hdr.push_back(pick_blank());
        if ($urandom_range(0, 4) == 0)
            hdr.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_DASH);
        case ($urandom_range(0, 9))
            7, 8:    digits = $urandom_range(4, 7);
            9:       digits = $urandom_range(17, 21);
            default: digits = $urandom_range(1, 3);
        endcase
        repeat (digits) hdr.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0)
            hdr.push_back(8'($urandom_range(1, 255)));
    endtask

    task automatic make_random_header();
        int kind;
        int cut;
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
            repeat ($urandom_range(1, 10)) hdr.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 4) begin
            // break the prefix partway through
            cut = $urandom_range(0, 5);
            for (int i = 0; i < cut; i++)
                hdr.push_back(PREFIX_TEXT[i]);
            hdr.push_back($urandom_range(0, 1) ? CHAR_NUL : 8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 3)) hdr.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_text("bytes=");
            if ($urandom_range(0, 99) == 0) begin
                repeat ($urandom_range(120, 140))
                    hdr.push_back($urandom_range(0, 3) == 0 ?
                                  CHAR_DASH : 8'(CHAR_ZERO + $urandom_range(0, 9)));
            end else begin
                add_number();
                if ($urandom_range(0, 5) == 0) begin
                    hdr.push_back(CHAR_DASH);
                    add_number();
                end
                if ($urandom_range(0, 19) != 0)
                    hdr.push_back(CHAR_DASH);
                add_number();
                if ($urandom_range(0, 19) == 0) begin
                    hdr.push_back(CHAR_NUL);
                    repeat ($urandom_range(0, 3)) hdr.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_axis_tready <= 1'b0;
            end
            @(negedge aclk);
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    initial begin
        #2_000_000;
        $display("[http_byte_range_parser] ERROR");
        $finish;
    end

    initial begin
        int n_headers;
        int base_count;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_case("bytes=0-99", 1000);
        run_case("bytes=-500", 1000);
        run_case("bytes=-5000", 1000);
        run_case("bytes=-0", 1000);
        run_case("bytes=-", 1000);
        run_case("bytes=100", 1000);
        run_case("bytex=0-1", 1000);
        add_text("byt");
        hdr.push_back(CHAR_NUL);
        add_text("es=0-1");
        send_header(1000);
        run_case("bytes=-10", 0);
        run_case("bytes=500-", 1000);
        run_case("bytes=9-3", 1000);
        run_case("bytes= +5 -\t20", 1000);
        run_case("bytes=-5-10", 1000);
        run_case("bytes=--5", 1000);
        run_case("bytes=-abc", 1000);
        run_case("bytes=99999999999999999999-", SIZE_MAX);
        run_case("bytes=0-9223372036854775808", SIZE_MAX);
        run_case("bytes=-9223372036854775807", SIZE_MAX);
        run_case("bytes=-9223372036854775808", 0);
        run_case("bytes=0-", SIZE_MAX);
        run_case("bytes=", 1000);
        run_case("b", 5);
        // bytes after the terminator are dropped
        add_text("bytes=0-5");
        hdr.push_back(CHAR_NUL);
        add_text("-9x");
        send_header(1000);
        hdr.push_back(CHAR_NUL);
        send_header(7);
        // body fills the limit exactly; the trailing dash must be dropped
        add_text("bytes=1-5");
        repeat (124) hdr.push_back(CHAR_SPACE);
        add_text("-9");
        send_header(1000);
        wait_drained();

        n_headers  = 0;
        base_count = bytes_sent;
        while (bytes_sent - base_count < RANDOM_BYTES) begin
            if (n_headers % 25 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            make_random_header();
            send_header(rand_size());
            n_headers++;
            if (n_headers % 60 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[http_byte_range_parser] OK");
        else
            $display("[http_byte_range_parser] ERROR");
        $finish;
    end

endmodule
